FILE: rtl/mi4_pkg.sv
// Shared constants, command and status types and index helpers for the 4x4 matrix inverter.
`timescale 1ns / 1ps

package mi4_pkg;

    localparam int ELEMENT_WIDTH = 32;
    localparam int FRACTION_BITS = 16;

    localparam int EW      = ELEMENT_WIDTH;
    localparam int MUL_W   = EW + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int PAIR_W  = 2 * EW;
    localparam int ACC_W   = 3 * EW + 4;
    localparam int ACC_X   = 4 * EW;
    localparam int DET_W   = 4 * EW + 8;
    localparam int NUM_W   = ACC_W + 2 * FRACTION_BITS;
    localparam int DSH_W   = DET_W + EW;
    localparam int QCNT_W  = $clog2(EW);
    localparam int TDATA_W = ((EW + 4 + 7) / 8) * 8;
    localparam int TUSER_W = 2;

    // Multiplier operand selections.
    localparam logic [1:0] MS_XY  = 2'd0;
    localparam logic [1:0] MS_PLO = 2'd1;
    localparam logic [1:0] MS_PHI = 2'd2;
    localparam logic [1:0] MS_CHK = 2'd3;

    typedef struct packed {
        logic       load_wr;
        logic       rd_en;
        logic [3:0] addr_a;
        logic [3:0] addr_b;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic [1:0] chunk;
        logic       pair_ld;
        logic       acc_clr;
        logic       acc_add;
        logic       acc_hi;
        logic       acc_neg;
        logic       adj_wr;
        logic       adj_rd;
        logic [3:0] adj_idx;
        logic       det_clr;
        logic       det_add;
        logic       dmag_ld;
        logic       div_init;
        logic       div_big;
        logic       div_step;
        logic       out_ld;
        logic       out_sing;
        logic       out_last;
    } mi4_cmd_t;

    typedef struct packed {
        logic det_zero;
        logic out_free;
    } mi4_stat_t;

    // Index i of a 3-element minor mapped back to a 4-element line, skipping line s.
    function automatic logic [1:0] mi4_skip(input logic [1:0] i, input logic [1:0] s);
        return (i >= s) ? (i + 2'd1) : i;
    endfunction

    // Column picked by minor row i in permutation term t of a 3x3 determinant.
    function automatic logic [1:0] mi4_perm_col(input logic [2:0] t, input logic [1:0] i);
        logic [5:0] p;
        case (t)
            3'd0:    p = {2'd2, 2'd1, 2'd0};
            3'd1:    p = {2'd0, 2'd2, 2'd1};
            3'd2:    p = {2'd1, 2'd0, 2'd2};
            3'd3:    p = {2'd1, 2'd2, 2'd0};
            3'd4:    p = {2'd0, 2'd1, 2'd2};
            3'd5:    p = {2'd2, 2'd0, 2'd1};
            default: p = {2'd2, 2'd1, 2'd0};
        endcase
        case (i)
            2'd0:    return p[1:0];
            2'd1:    return p[3:2];
            default: return p[5:4];
        endcase
    endfunction

    // Odd permutations carry a minus sign.
    function automatic logic mi4_perm_neg(input logic [2:0] t);
        return (t >= 3'd3);
    endfunction

endpackage

FILE: rtl/mi4_datapath.sv
// Datapath of the matrix inverter: element store, multiplier, accumulators, divider, output register.
`timescale 1ns / 1ps

module mi4_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  mi4_pkg::mi4_cmd_t                cmd,
    output mi4_pkg::mi4_stat_t               stat,
    input  logic [mi4_pkg::EW-1:0]           s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mi4_pkg::TDATA_W-1:0]      m_tdata,
    output logic [mi4_pkg::TUSER_W-1:0]      m_tuser,
    output logic                             m_tlast
);
    import mi4_pkg::*;

    logic [EW-1:0]             mat_mem [16];
    logic [EW-1:0]             rda_reg, rdb_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [PAIR_W-1:0]         pair_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   adj_mem [16];
    logic signed [ACC_W-1:0]   adj_rd_reg;
    logic signed [DET_W-1:0]   det_reg;
    logic [DET_W-1:0]          dmag_reg;
    logic                      dneg_reg;
    logic [NUM_W-1:0]          rem_reg;
    logic [DSH_W-1:0]          dsh_reg;
    logic [EW-1:0]             q_reg;
    logic                      qneg_reg;
    logic                      big_reg;
    logic                      out_valid_reg;
    logic [EW-1:0]             out_val_reg;
    logic [3:0]                out_idx_reg;
    logic                      out_sing_reg, out_sat_reg, out_last_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic [ACC_X-1:0]          acc_x;
    logic [EW-1:0]             chunk_bits;
    logic signed [ACC_W-1:0]   acc_term;
    logic signed [DET_W-1:0]   det_ext, det_term;
    logic [ACC_W-1:0]          amag;
    logic [DSH_W-1:0]          rem_x;
    logic                      step_ge;
    logic [EW-1:0]             lim, res, qval;
    logic                      sat;

    // Multiplier operands.
    always_comb begin
        acc_x      = ACC_X'(acc_reg);
        chunk_bits = acc_x[cmd.chunk*EW +: EW];
        mul_a      = {rda_reg[EW-1], rda_reg};
        case (cmd.mul_sel)
            MS_XY:   mul_b = {rdb_reg[EW-1], rdb_reg};
            MS_PLO:  mul_b = {1'b0, pair_reg[EW-1:0]};
            MS_PHI:  mul_b = {pair_reg[PAIR_W-1], pair_reg[PAIR_W-1 -: EW]};
            MS_CHK:  mul_b = (cmd.chunk == 2'd3) ? {chunk_bits[EW-1], chunk_bits}
                                                  : {1'b0, chunk_bits};
            default: mul_b = '0;
        endcase
        prod_next = mul_a * mul_b;
    end

    // Accumulator terms.
    always_comb begin
        acc_term = cmd.acc_hi ? (ACC_W'(prod_reg) <<< EW) : ACC_W'(prod_reg);
        det_ext  = DET_W'(prod_reg);
        case (cmd.chunk)
            2'd0:    det_term = det_ext;
            2'd1:    det_term = det_ext <<< EW;
            2'd2:    det_term = det_ext <<< (2 * EW);
            2'd3:    det_term = det_ext <<< (3 * EW);
            default: det_term = det_ext;
        endcase
        amag    = adj_rd_reg[ACC_W-1] ? ACC_W'(-adj_rd_reg) : ACC_W'(adj_rd_reg);
        rem_x   = DSH_W'(rem_reg);
        step_ge = (rem_x >= dsh_reg);
    end

    // Saturating result formatting.
    always_comb begin
        lim  = qneg_reg ? (EW'(1) << (EW - 1)) : ((EW'(1) << (EW - 1)) - EW'(1));
        sat  = big_reg || (q_reg > lim);
        res  = sat ? lim : q_reg;
        qval = qneg_reg ? (EW'(0) - res) : res;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_wr) begin
            mat_mem[cmd.addr_a] <= s_tdata;
        end
        if (cmd.rd_en) begin
            rda_reg <= mat_mem[cmd.addr_a];
            rdb_reg <= mat_mem[cmd.addr_b];
        end
        if (cmd.adj_wr) begin
            adj_mem[cmd.adj_idx] <= acc_reg;
        end
        if (cmd.adj_rd) begin
            adj_rd_reg <= adj_mem[cmd.adj_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= prod_next;
        end
        if (cmd.pair_ld) begin
            pair_reg <= PAIR_W'(prod_reg);
        end
        if (cmd.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd.acc_add) begin
            acc_reg <= cmd.acc_neg ? (acc_reg - acc_term) : (acc_reg + acc_term);
        end
        if (cmd.det_clr) begin
            det_reg <= '0;
        end else if (cmd.det_add) begin
            det_reg <= det_reg + det_term;
        end
        if (cmd.dmag_ld) begin
            dneg_reg <= det_reg[DET_W-1];
            dmag_reg <= det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        end
        if (cmd.div_init) begin
            rem_reg  <= NUM_W'(amag) << (2 * FRACTION_BITS);
            dsh_reg  <= DSH_W'(dmag_reg) << (EW - 1);
            qneg_reg <= adj_rd_reg[ACC_W-1] ^ dneg_reg;
            q_reg    <= '0;
        end else if (cmd.div_step) begin
            if (step_ge) begin
                rem_reg <= NUM_W'(rem_x - dsh_reg);
            end
            q_reg   <= {q_reg[EW-2:0], step_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.div_big) begin
            // A quotient of 2^EW or more can only saturate.
            big_reg <= (rem_x >= (DSH_W'(dmag_reg) << EW));
        end
        if (cmd.out_ld) begin
            out_val_reg  <= cmd.out_sing ? '0 : qval;
            out_idx_reg  <= cmd.out_sing ? 4'd0 : cmd.adj_idx;
            out_sing_reg <= cmd.out_sing;
            out_sat_reg  <= cmd.out_sing ? 1'b0 : sat;
            out_last_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_ld) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.det_zero = (det_reg == '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_idx_reg, out_val_reg});
    assign m_tuser  = {out_sat_reg, out_sing_reg};
    assign m_tlast  = out_last_reg;

endmodule

FILE: rtl/mi4_ctrl.sv
// Sequencing state machine of the matrix inverter.
`timescale 1ns / 1ps

module mi4_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mi4_pkg::mi4_stat_t  stat,
    output mi4_pkg::mi4_cmd_t   cmd
);
    import mi4_pkg::*;

    localparam logic [4:0] S_LOAD = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_M1   = 5'd2;
    localparam logic [4:0] S_P1   = 5'd3;
    localparam logic [4:0] S_M2   = 5'd4;
    localparam logic [4:0] S_A2   = 5'd5;
    localparam logic [4:0] S_A3   = 5'd6;
    localparam logic [4:0] S_WR   = 5'd7;
    localparam logic [4:0] S_DM   = 5'd8;
    localparam logic [4:0] S_DA   = 5'd9;
    localparam logic [4:0] S_DMAG = 5'd10;
    localparam logic [4:0] S_SING = 5'd11;
    localparam logic [4:0] S_QRD  = 5'd12;
    localparam logic [4:0] S_QLD  = 5'd13;
    localparam logic [4:0] S_QBIG = 5'd14;
    localparam logic [4:0] S_QDIV = 5'd15;
    localparam logic [4:0] S_QOUT = 5'd16;

    logic [4:0]        state_reg, state_next;
    logic [3:0]        load_cnt_reg, load_cnt_next;
    logic [3:0]        k_reg, k_next;
    logic [2:0]        t_reg, t_next;
    logic [1:0]        j_reg, j_next;
    logic [QCNT_W-1:0] qc_reg, qc_next;

    logic [1:0] row_r, col_c;
    logic [3:0] addr_x, addr_y, addr_z;

    // Cofactor (r,c) uses the minor without row c and column r.
    always_comb begin
        row_r  = k_reg[3:2];
        col_c  = k_reg[1:0];
        addr_x = {mi4_skip(2'd0, col_c), mi4_skip(mi4_perm_col(t_reg, 2'd0), row_r)};
        addr_y = {mi4_skip(2'd1, col_c), mi4_skip(mi4_perm_col(t_reg, 2'd1), row_r)};
        addr_z = {mi4_skip(2'd2, col_c), mi4_skip(mi4_perm_col(t_reg, 2'd2), row_r)};
    end

    always_comb begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        k_next        = k_reg;
        t_next        = t_reg;
        j_next        = j_reg;
        qc_next       = qc_reg;
        cmd           = '0;
        cmd.adj_idx   = k_reg;
        cmd.chunk     = j_reg;
        cmd.acc_neg   = mi4_perm_neg(t_reg) ^ row_r[0] ^ col_c[0];
        s_tready      = 1'b0;

        case (state_reg)
            S_LOAD: begin
                s_tready   = 1'b1;
                cmd.addr_a = load_cnt_reg;
                if (s_tvalid) begin
                    cmd.load_wr   = 1'b1;
                    load_cnt_next = load_cnt_reg + 4'd1;
                    if (load_cnt_reg == 4'd15) begin
                        cmd.det_clr = 1'b1;
                        k_next      = 4'd0;
                        t_next      = 3'd0;
                        state_next  = S_RD;
                    end
                end
            end
            S_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.addr_a  = addr_x;
                cmd.addr_b  = addr_y;
                cmd.acc_clr = (t_reg == 3'd0);
                state_next  = S_M1;
            end
            S_M1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_XY;
                cmd.rd_en   = 1'b1;
                cmd.addr_a  = addr_z;
                state_next  = S_P1;
            end
            S_P1: begin
                cmd.pair_ld = 1'b1;
                state_next  = S_M2;
            end
            S_M2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_PLO;
                state_next  = S_A2;
            end
            S_A2: begin
                cmd.acc_add = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_PHI;
                state_next  = S_A3;
            end
            S_A3: begin
                cmd.acc_add = 1'b1;
                cmd.acc_hi  = 1'b1;
                if (t_reg == 3'd5) begin
                    t_next     = 3'd0;
                    state_next = S_WR;
                end else begin
                    t_next     = t_reg + 3'd1;
                    state_next = S_RD;
                end
            end
            S_WR: begin
                cmd.adj_wr = 1'b1;
                if (col_c == 2'd0) begin
                    // First-column cofactors feed the determinant along row zero.
                    cmd.rd_en  = 1'b1;
                    cmd.addr_a = {2'd0, row_r};
                    j_next     = 2'd0;
                    state_next = S_DM;
                end else if (k_reg == 4'd15) begin
                    state_next = S_DMAG;
                end else begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_RD;
                end
            end
            S_DM: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MS_CHK;
                state_next  = S_DA;
            end
            S_DA: begin
                cmd.det_add = 1'b1;
                if (j_reg == 2'd3) begin
                    k_next     = k_reg + 4'd1;
                    state_next = S_RD;
                end else begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_DM;
                end
            end
            S_DMAG: begin
                cmd.dmag_ld = 1'b1;
                k_next      = 4'd0;
                state_next  = stat.det_zero ? S_SING : S_QRD;
            end
            S_SING: begin
                if (stat.out_free) begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_sing = 1'b1;
                    cmd.out_last = 1'b1;
                    state_next   = S_LOAD;
                end
            end
            S_QRD: begin
                cmd.adj_rd = 1'b1;
                state_next = S_QLD;
            end
            S_QLD: begin
                cmd.div_init = 1'b1;
                state_next   = S_QBIG;
            end
            S_QBIG: begin
                cmd.div_big = 1'b1;
                qc_next     = '0;
                state_next  = S_QDIV;
            end
            S_QDIV: begin
                cmd.div_step = 1'b1;
                qc_next      = qc_reg + QCNT_W'(1);
                if (qc_reg == QCNT_W'(EW - 1)) begin
                    state_next = S_QOUT;
                end
            end
            S_QOUT: begin
                if (stat.out_free) begin
                    cmd.out_ld   = 1'b1;
                    cmd.out_last = (k_reg == 4'd15);
                    if (k_reg == 4'd15) begin
                        state_next = S_LOAD;
                    end else begin
                        k_next     = k_reg + 4'd1;
                        state_next = S_QRD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= 4'd0;
            k_reg        <= 4'd0;
            t_reg        <= 3'd0;
            j_reg        <= 2'd0;
            qc_reg       <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            k_reg        <= k_next;
            t_reg        <= t_next;
            j_reg        <= j_next;
            qc_reg       <= qc_next;
        end
    end

endmodule

FILE: rtl/matrix4x4_inverse.sv
// Top level of the 4x4 fixed-point matrix inverter (cofactor and adjugate method).
`timescale 1ns / 1ps

// Usage:
// The slave channel takes one signed Q16.16 matrix element per request, row-major,
// index 0 to 15, one per cycle while s_tready is high. The sixteenth element starts
// the computation; s_tready then stays low until the last result has been placed in
// the output register.
// The sixteen cofactors are built exactly from 3x3 minors, six triple products each,
// on one shared 33x33 multiplier, which also forms the four determinant terms. Each
// inverse element then goes through a restoring divider that settles one quotient bit
// per cycle. A singular matrix gives one result instead, with the singular flag and
// tlast set.
// The master channel holds each result in an output register; if the receiver stalls,
// the block waits with that request held stable and the next quotient waiting.
// After the last result is registered the block takes the next matrix at once.
// Reset (aresetn low, synchronous) returns to loading at index 0 and drops m_tvalid.
module matrix4x4_inverse (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mi4_pkg::EW-1:0]            s_tdata,   // element_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mi4_pkg::TDATA_W-1:0]       m_tdata,   // inverse_value, element_index, zero pad
    output logic [mi4_pkg::TUSER_W-1:0]       m_tuser,   // singular, saturated
    output logic                              m_tlast
);
    import mi4_pkg::*;

    mi4_cmd_t  cmd;
    mi4_stat_t stat;

    mi4_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mi4_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

FILE: rtl/mi4_check.sv
// Port-level assertions for the matrix inverter and their binding to the top level.
`timescale 1ns / 1ps

module mi4_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mi4_pkg::TDATA_W-1:0]   m_tdata,
    input logic [mi4_pkg::TUSER_W-1:0]   m_tuser,
    input logic                          m_tlast
);
    import mi4_pkg::*;

    // A stalled result request stays up.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    // A singular result carries tlast and is all zero but for its singular flag.
    a_sing_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast && !m_tuser[1] && (m_tdata == '0))
        else $error("singular result malformed");

    // The final result of a regular run carries index 15.
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast && !m_tuser[0] |-> (m_tdata[EW+3:EW] == 4'd15))
        else $error("last flag on wrong index");

    // No input is taken while the block is producing results of a pending matrix.
    a_no_load: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !(s_tvalid && s_tready))
        else $error("input accepted mid-run");

endmodule

bind matrix4x4_inverse mi4_check u_mi4_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: test/tb_matrix4x4_inverse.sv
// Self-checking testbench for the 4x4 fixed-point matrix inverter with its own exact predictor.
`timescale 1ns / 1ps

module tb_matrix4x4_inverse;

    import mi4_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        singular;
        logic        saturated;
        logic        last;
    } inv_result_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLDOFF_CYCLES = 3000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [EW-1:0]        s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic [TUSER_W-1:0]   m_tuser;
    logic                 m_tlast;

    logic [31:0]          element_queue[$];
    inv_result_t          inverse_queue[$];
    logic signed [31:0]   loaded_matrix[16];
    int                   load_slot = 0;
    int                   mismatch_count = 0;
    int                   results_seen = 0;
    int                   idle_cycles = 0;
    int                   burst_left = 0;
    int                   gap_left = 0;
    int                   holdoff_left = 0;
    bit                   holdoff_done = 1'b0;
    int                   stall_mode = 0;

    always #6 aclk = ~aclk;

    matrix4x4_inverse i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Determinant of the 3x3 minor that leaves out row sr and column sc.
    function automatic wide_t minor_det(int sr, int sc);
        int    rr[3];
        int    cc[3];
        int    n;
        wide_t e[3][3];
        n = 0;
        for (int k = 0; k < 4; k++) if (k != sr) begin rr[n] = k; n++; end
        n = 0;
        for (int k = 0; k < 4; k++) if (k != sc) begin cc[n] = k; n++; end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = loaded_matrix[rr[i] * 4 + cc[j]];
        return e[0][0] * (e[1][1] * e[2][2] - e[1][2] * e[2][1])
             - e[0][1] * (e[1][0] * e[2][2] - e[1][2] * e[2][0])
             + e[0][2] * (e[1][0] * e[2][1] - e[1][1] * e[2][0]);
    endfunction

    // Exact adjugate over determinant, truncated toward zero and clipped to Q16.16.
    task automatic predict_inverse();
        wide_t       adj[16];
        wide_t       det;
        wide_t       quot;
        inv_result_t res;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++) begin
                adj[r * 4 + c] = minor_det(c, r);
                if ((r + c) % 2 == 1) adj[r * 4 + c] = -adj[r * 4 + c];
            end
        det = 0;
        for (int k = 0; k < 4; k++) det = det + wide_t'(loaded_matrix[k]) * adj[k * 4];
        if (det == 0) begin
            res = '{value: '0, index: '0, singular: 1'b1, saturated: 1'b0, last: 1'b1};
            inverse_queue.push_back(res);
            return;
        end
        for (int k = 0; k < 16; k++) begin
            quot = (adj[k] <<< (2 * FRACTION_BITS)) / det;
            res.index = k[3:0];
            res.singular = 1'b0;
            res.last = (k == 15);
            res.saturated = 1'b1;
            if (quot > wide_t'(32'sh7fffffff)) res.value = 32'h7fffffff;
            else if (quot < -wide_t'(64'sh80000000)) res.value = 32'h80000000;
            else begin
                res.value = quot[31:0];
                res.saturated = 1'b0;
            end
            inverse_queue.push_back(res);
        end
    endtask

    // One matrix of a random flavor: full-range bits, small values, singular or nearly so.
    task automatic add_random_matrix();
        logic [31:0] m[16];
        int          flavor;
        int          src;
        flavor = $urandom_range(0, 4);
        for (int k = 0; k < 16; k++) begin
            case (flavor)
                0:       m[k] = $urandom;
                1, 2:    m[k] = $urandom_range(0, 32'h80000) - 32'h40000;
                3:       m[k] = (k % 5 == 0) ? $urandom_range(1, 8) : $urandom_range(0, 3);
                default: m[k] = $urandom_range(0, 32'h4000) - 32'h2000;
            endcase
        end
        // Repeating a row in place of another forces a zero determinant.
        if (flavor == 2) begin
            src = $urandom_range(0, 3);
            for (int c = 0; c < 4; c++) m[((src + 1) % 4) * 4 + c] = m[src * 4 + c];
        end
        for (int k = 0; k < 16; k++) element_queue.push_back(m[k]);
    endtask

    // Sender: bursts of random length separated by random gaps; the request is held until
    // accepted. Accepted elements feed the predictor.
    always @(posedge aclk) begin
        logic [31:0] next_element;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (s_tvalid && s_tready) begin
                loaded_matrix[load_slot] = s_tdata;
                if (load_slot == 15) predict_inverse();
                load_slot = (load_slot + 1) % 16;
                void'(element_queue.pop_front());
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (element_queue.size() > 0) begin
                next_element = element_queue[0];
                s_tvalid <= 1'b1;
                s_tdata <= next_element;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: switches among stall patterns, and once holds off for a long stretch so
    // that the block stalls its input while the sender keeps offering.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left--;
            m_tready <= 1'b0;
        end else if (!holdoff_done && results_seen >= 40) begin
            holdoff_done = 1'b1;
            holdoff_left = HOLDOFF_CYCLES;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 99) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    // Result monitor: each accepted request is checked against the oldest expectation.
    always @(posedge aclk) begin
        inv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (inverse_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: value %h index %0d tuser %b last %b",
                             m_tdata[31:0], m_tdata[35:32], m_tuser, m_tlast);
            end else begin
                want = inverse_queue.pop_front();
                if (m_tdata[31:0] !== want.value || m_tdata[35:32] !== want.index ||
                    m_tuser[0] !== want.singular || m_tuser[1] !== want.saturated ||
                    m_tlast !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"Result differs: expected value %h index %0d sing %b ",
                                  "sat %b last %b, got value %h index %0d sing %b sat %b ",
                                  "last %b"},
                                 want.value, want.index, want.singular, want.saturated,
                                 want.last, m_tdata[31:0], m_tdata[35:32], m_tuser[0],
                                 m_tuser[1], m_tlast);
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither channel accepts a request.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        // Identity matrix at 1.0.
        for (int k = 0; k < 16; k++) element_queue.push_back((k % 5 == 0) ? 32'h00010000 : 0);
        // Zero matrix: singular.
        for (int k = 0; k < 16; k++) element_queue.push_back(32'h0);
        // Range extremes and single-LSB entries on the diagonal, one minus-one-LSB entry off it: clipped results.
        for (int k = 0; k < 16; k++)
            element_queue.push_back((k == 0) ? 32'h7fffffff : (k == 5) ? 32'h80000000 :
                                    (k % 5 == 0) ? 32'h00000001 : (k == 3) ? 32'hffffffff : 0);
        for (int n = 0; n < 26; n++) add_random_matrix();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        wait (element_queue.size() == 0 && !s_tvalid);
        wait (inverse_queue.size() == 0);
        repeat (50) @(posedge aclk);
        if (mismatch_count == 0 && inverse_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
